>>> design/amtx_pkg.sv
// Shared types and constants of the AM transmitter modulator.
package amtx_pkg;

	typedef struct packed {
		logic              cmd;
		logic              rf_switch_off;
		logic              pulse_high;
		logic [2:0]        jack_connected;
		logic signed [11:0] audio_one;
		logic signed [11:0] audio_two;
		logic signed [11:0] wav_sample;
		logic [11:0]       knob_main;
		logic [11:0]       knob_fine;
		logic [11:0]       knob_volume;
		logic signed [11:0] cv_tune;
	} amtx_req_t;

	typedef struct packed {
		logic signed [11:0] audio_out;
		logic              rf_led;
		logic [11:0]       led_low;
		logic [11:0]       led_mid;
		logic [11:0]       led_high;
		logic [8:0]        pwm_compare;
		logic [8:0]        pwm_wrap;
	} amtx_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VOL,
		ST_SIG,
		ST_HI,
		ST_MID,
		ST_PER1,
		ST_PER2,
		ST_AM,
		ST_WRAP
	} amtx_state_t;

	// request commands
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_WRAP   = 1'b1;

	// register index (paddr[2])
	localparam logic REG_KNOB_WINDOW = 1'b0;

	localparam logic [11:0] KNOB_WINDOW_RST = 12'd5;
	localparam logic [20:0] PERIOD_RST      = 21'd1024000;
	localparam logic [20:0] PERIOD_BASE     = 21'd511999;
	localparam logic [11:0] KNOB_MAX        = 12'd4095;
	localparam logic [11:0] VOL_DEAD        = 12'd30;
	localparam logic [11:0] CARRIER_BIAS    = 12'd2048;
	localparam logic [11:0] LED_FULL        = 12'd4095;
	localparam logic [11:0] LED_HI_KNEE     = 12'd1024;
	localparam logic [11:0] LED_MID_KNEE    = 12'd256;

	localparam int MUL_W         = 17;
	localparam int COARSE_STEP   = 253;
	localparam int FINE_STEP     = 6;
	localparam int LED_HI_SCALE  = 5461;
	localparam int LED_MID_SCALE = 21845;
	localparam int AUDIO_LIM     = 2047;
	localparam int PWM_MAX       = 511;

endpackage

>>> design/amtx_cfg.sv
// APB register block holding the tuning-knob hysteresis window.
module amtx_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [11:0] knob_window
);
	import amtx_pkg::*;

	logic        wr_en;
	logic [11:0] knob_window_q;

	assign pready      = 1'b1;
	assign wr_en       = psel & penable & pwrite & (paddr[2] == REG_KNOB_WINDOW);
	assign knob_window = knob_window_q;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_KNOB_WINDOW) begin
			prdata = {20'd0, knob_window_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knob_window_q <= KNOB_WINDOW_RST;
		end else if (wr_en) begin
			knob_window_q <= pwdata[11:0];
		end
	end

endmodule

>>> design/am_transmitter_modulator.sv
// AM carrier modulator: sequencer around one shared 17x17 signed multiplier.
// Sample request: steps VOL, SIG, HI, MID, PER1, PER2 and AM in order, result registered out of AM.
// Wrap tick: step WRAP, result registered out of WRAP; a new request is taken only back in idle.
// The seven multiplies of a sample run one per cycle through the single multiplier.
// A stalled result holds the sequencer in its last step until the output register frees.
// Reset clears the hysteresis, duty and residue state, loads the period with 1024000,
// and returns the window to 5.
module am_transmitter_modulator #(
	parameter int FRACTION_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  amtx_pkg::amtx_req_t req_data,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output amtx_pkg::amtx_rsp_t rsp_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import amtx_pkg::*;

	localparam int VAL_W = 22;
	localparam int INT_W = VAL_W - FRACTION_BITS;

	amtx_state_t state_q, state_d;
	amtx_req_t   req_q;
	amtx_rsp_t   rsp_q, rsp_next;
	logic        rsp_valid_q;

	logic [11:0] knob_window;

	// model state
	logic [11:0]              held_q;
	logic [19:0]              am_level_q;
	logic [20:0]              period_q;
	logic [FRACTION_BITS-1:0] am_res_q;
	logic [FRACTION_BITS-1:0] per_res_q;

	// sequencer scratch
	logic [11:0]        vol2_q;
	logic signed [11:0] sig_q;
	logic [11:0]        led_hi_q;
	logic [11:0]        led_mid_q;
	logic [20:0]        acc_q;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p;
	logic signed [2*MUL_W-1:0] sig_shr;
	logic signed [11:0]        sig_clamp;

	logic               req_acc, rsp_free, finish;
	logic signed [12:0] sig_sum;
	logic               rf_on;
	logic [11:0]        vol;
	logic [10:0]        sig_mag;
	logic [11:0]        led_sig;
	logic [11:0]        led_low;
	logic [11:0]        carrier;
	logic signed [13:0] km_s, win_hi, win_lo;
	logic               held_move;
	logic signed [13:0] fine_sum;
	logic signed [22:0] per_calc;

	logic [VAL_W-1:0] am_diff, per_diff;
	logic [INT_W-1:0] am_int, per_int;
	logic [8:0]       am_sat, per_sat;

	amtx_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.knob_window (knob_window)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid & ~req_stall;
	assign rsp_free  = ~rsp_valid_q | ~rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// ---- per-request operands ----
	always_comb begin
		sig_sum = '0;
		if (req_q.jack_connected[0]) begin
			sig_sum = sig_sum + {req_q.audio_one[11], req_q.audio_one};
		end
		if (req_q.jack_connected[1]) begin
			sig_sum = sig_sum + {req_q.audio_two[11], req_q.audio_two};
		end
		if (req_q.jack_connected[1:0] == 2'b00) begin
			sig_sum = sig_sum + {req_q.wav_sample[11], req_q.wav_sample};
		end
	end

	assign rf_on = ~req_q.rf_switch_off & (~req_q.jack_connected[2] | req_q.pulse_high);
	assign vol   = (req_q.knob_volume > VOL_DEAD) ? (req_q.knob_volume - VOL_DEAD) : '0;

	assign sig_mag = sig_q[11] ? 11'(-sig_q) : 11'(sig_q);
	assign led_sig = {sig_mag, 1'b0};
	assign led_low = (led_sig >= LED_MID_KNEE) ? LED_FULL : {led_sig[7:0], 4'b0000};
	assign carrier = 12'(sig_q) + CARRIER_BIAS;

	assign km_s      = $signed({2'b00, req_q.knob_main});
	assign win_hi    = $signed({2'b00, held_q}) + $signed({2'b00, knob_window});
	assign win_lo    = $signed({2'b00, held_q}) - $signed({2'b00, knob_window});
	assign held_move = (km_s > win_hi) || (km_s < win_lo);

	assign fine_sum = $signed({2'b00, req_q.knob_fine}) + 14'(req_q.cv_tune);

	// ---- shared multiplier ----
	assign mul_p = mul_a * mul_b;

	// arithmetic shift by 12 then clamp to +-2047
	assign sig_shr = mul_p >>> 12;
	always_comb begin
		if (sig_shr > AUDIO_LIM) begin
			sig_clamp = 12'(AUDIO_LIM);
		end else if (sig_shr < -AUDIO_LIM) begin
			sig_clamp = 12'(-AUDIO_LIM);
		end else begin
			sig_clamp = sig_shr[11:0];
		end
	end

	assign per_calc = $signed({2'b00, acc_q}) - 23'(mul_p);

	// ---- truncation with error feedback; residues stored as magnitudes ----
	assign am_diff  = VAL_W'(am_level_q) + VAL_W'(am_res_q);
	assign per_diff = VAL_W'(period_q) + VAL_W'(per_res_q);
	assign am_int   = am_diff[VAL_W-1:FRACTION_BITS];
	assign per_int  = per_diff[VAL_W-1:FRACTION_BITS];
	assign am_sat   = (32'(am_int) > PWM_MAX) ? 9'(PWM_MAX) : 9'(am_int);
	assign per_sat  = (32'(per_int) > PWM_MAX) ? 9'(PWM_MAX) : 9'(per_int);

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					state_d = (req_data.cmd == CMD_WRAP) ? ST_WRAP : ST_VOL;
				end
			end
			ST_VOL:  state_d = ST_SIG;
			ST_SIG:  state_d = ST_HI;
			ST_HI:   state_d = ST_MID;
			ST_MID:  state_d = ST_PER1;
			ST_PER1: state_d = ST_PER2;
			ST_PER2: state_d = ST_AM;
			ST_AM, ST_WRAP: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---- sequencer outputs: multiplier operands, result word ----
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		finish   = 1'b0;
		rsp_next = '0;
		case (state_q)
			ST_VOL: begin
				mul_a = MUL_W'($signed({1'b0, vol}));
				mul_b = MUL_W'($signed({1'b0, vol}));
			end
			ST_SIG: begin
				mul_a = MUL_W'(sig_sum);
				mul_b = MUL_W'($signed({1'b0, vol2_q}));
			end
			ST_HI: begin
				mul_a = MUL_W'($signed({1'b0, led_sig})) - MUL_W'($signed({1'b0, LED_HI_KNEE}));
				mul_b = MUL_W'(LED_HI_SCALE);
			end
			ST_MID: begin
				mul_a = MUL_W'($signed({1'b0, led_sig})) - MUL_W'($signed({1'b0, LED_MID_KNEE}));
				mul_b = MUL_W'(LED_MID_SCALE);
			end
			ST_PER1: begin
				mul_a = MUL_W'($signed({1'b0, KNOB_MAX - held_q}));
				mul_b = MUL_W'(COARSE_STEP);
			end
			ST_PER2: begin
				mul_a = MUL_W'(fine_sum);
				mul_b = MUL_W'(FINE_STEP);
			end
			ST_AM: begin
				mul_a = MUL_W'($signed({1'b0, carrier}));
				mul_b = MUL_W'($signed({1'b0, period_q[20:13]}));
				finish             = rsp_free;
				rsp_next.audio_out = sig_q;
				rsp_next.rf_led    = rf_on;
				rsp_next.led_low   = led_low;
				rsp_next.led_mid   = led_mid_q;
				rsp_next.led_high  = led_hi_q;
			end
			ST_WRAP: begin
				finish               = rsp_free;
				rsp_next.pwm_compare = am_sat;
				rsp_next.pwm_wrap    = per_sat;
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	// ---- control and model state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			held_q      <= '0;
			am_level_q  <= '0;
			period_q    <= PERIOD_RST;
			am_res_q    <= '0;
			per_res_q   <= '0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_VOL: begin
					if (held_move) begin
						held_q <= req_q.knob_main;
					end
				end
				ST_PER2: period_q <= per_calc[20:0];
				ST_AM: begin
					if (finish) begin
						am_level_q <= rf_on ? mul_p[19:0] : '0;
					end
				end
				ST_WRAP: begin
					if (finish) begin
						am_res_q  <= am_diff[FRACTION_BITS-1:0];
						per_res_q <= per_diff[FRACTION_BITS-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q <= req_data;
		end
		if (finish) begin
			rsp_q <= rsp_next;
		end
		case (state_q)
			ST_VOL: vol2_q <= mul_p[23:12];
			ST_SIG: sig_q  <= sig_clamp;
			ST_HI:  led_hi_q <= (led_sig < LED_HI_KNEE) ? '0 : mul_p[23:12];
			ST_MID: begin
				if (led_sig < LED_MID_KNEE) begin
					led_mid_q <= '0;
				end else if (led_sig >= LED_HI_KNEE) begin
					led_mid_q <= LED_FULL;
				end else begin
					led_mid_q <= mul_p[23:12];
				end
			end
			ST_PER1: acc_q <= PERIOD_BASE + mul_p[20:0];
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> req_stall)
		else $error("request accepted without sequencer going busy");

	a_rsp_from_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_AM || state_q == ST_WRAP))
		else $error("result raised outside a final step");

	// period stays within the range reachable by any knob and cv setting
	a_period_range: assert property (@(posedge clk) disable iff (!arst_n)
		(period_q >= 21'd475147) && (period_q <= 21'd1560322))
		else $error("period value out of range");

	a_tick_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.pwm_wrap != '0) |->
		(rsp_data.audio_out == '0) && !rsp_data.rf_led)
		else $error("wrap tick result carries audio fields");

	a_audio_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.audio_out != -12'sd2048))
		else $error("audio output escaped clamp");
`endif

endmodule
